FILE: rtl/core/qfir_pkg.sv
`timescale 1ns / 1ps

package qfir_pkg;

   // Q15 data and accumulator widths
   localparam int DATA_W    = 16;
   localparam int PROD_W    = 32;
   localparam int ACC_W     = 32;
   localparam int CFG_W     = 7;
   localparam int IDX_W     = 6;
   localparam int OUT_SHIFT = 16;

   // Rounding offset loaded into the accumulator at the start of a sample
   localparam logic signed [ACC_W-1:0] ROUND_INIT = 32'sd32768;

   // Transaction opcodes
   localparam logic OP_FILTER = 1'b0;
   localparam logic OP_COEF   = 1'b1;

   typedef logic signed [DATA_W-1:0] sample_type;
   typedef logic signed [ACC_W-1:0]  acc_type;

   // Per-cell control: rotate the ring, or load a coefficient in place
   typedef struct packed {
      logic shift;
      logic coef_we;
   } cell_ctrl_type;

   // Accumulator control: restart at the rounding offset, or issue a product
   typedef struct packed {
      logic clear;
      logic issue;
   } mac_ctrl_type;

endpackage

FILE: rtl/core/qfir_cell.sv
`timescale 1ns / 1ps

module qfir_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  qfir_pkg::cell_ctrl_type ctrl,
   input  qfir_pkg::sample_type   hist_in,
   input  qfir_pkg::sample_type   coef_in,
   input  qfir_pkg::sample_type   coef_wdata,
   output qfir_pkg::sample_type   hist_q,
   output qfir_pkg::sample_type   coef_q
);
   import qfir_pkg::*;

   sample_type hist_ff;
   sample_type coef_ff;

   // Hold one history entry and one coefficient; take the neighbour's on a shift
   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff <= '0;
         coef_ff <= '0;
      end else if (ctrl.coef_we) begin
         coef_ff <= coef_wdata;
      end else if (ctrl.shift) begin
         hist_ff <= hist_in;
         coef_ff <= coef_in;
      end
   end

   assign hist_q = hist_ff;
   assign coef_q = coef_ff;

endmodule

FILE: rtl/core/qfir_mac.sv
`timescale 1ns / 1ps

module qfir_mac (
   input  logic                   clock,
   input  logic                   reset,
   input  qfir_pkg::mac_ctrl_type ctrl,
   input  qfir_pkg::sample_type   hist,
   input  qfir_pkg::sample_type   coef,
   output qfir_pkg::acc_type      acc
);
   import qfir_pkg::*;

   logic signed [PROD_W-1:0] prod_ff;
   logic                     prod_vld_ff;
   acc_type                  acc_ff;
   logic signed [ACC_W+1:0]  sum_in;
   acc_type                  acc_in;

   // Register the product before it reaches the adder
   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
      end else begin
         prod_vld_ff <= ctrl.issue;
      end
      prod_ff <= PROD_W'(hist * coef);
   end

   // Add twice the product and clamp to signed 32 bits
   always_comb begin
      sum_in = (ACC_W+2)'(acc_ff) + ((ACC_W+2)'(prod_ff) <<< 1);
      if (sum_in[ACC_W+1:ACC_W-1] == 3'b000 || sum_in[ACC_W+1:ACC_W-1] == 3'b111) begin
         acc_in = sum_in[ACC_W-1:0];
      end else if (sum_in[ACC_W+1]) begin
         acc_in = {1'b1, {(ACC_W-1){1'b0}}};
      end else begin
         acc_in = {1'b0, {(ACC_W-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.clear) begin
         acc_ff <= ROUND_INIT;
      end else if (prod_vld_ff) begin
         acc_ff <= acc_in;
      end
   end

   assign acc = acc_ff;

endmodule

FILE: rtl/core/q15_fir_filter_core.sv
// A sample transaction gives its result after one full turn of the cell ring past the
// single shared multiply-accumulate unit. No new transaction is accepted until the result
// is loaded into the result register; a coefficient write is taken only in IDLE.
// Reset (synchronous, active high) clears history and coefficients and sets tap_count to 1.
`timescale 1ns / 1ps

module q15_fir_filter_core #(
   parameter int MAX_TAPS = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   // sample / coefficient transactions
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_opcode,
   input  logic signed [15:0]          req_sample,
   input  logic [5:0]                  req_coef_index,
   input  logic signed [15:0]          req_coef_value,
   input  logic                        req_last_sample,
   // filtered results
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [15:0]          rsp_filtered,
   output logic                        rsp_block_end,
   // tap_count register
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [qfir_pkg::CFG_W-1:0]  csr_wdata
);
   import qfir_pkg::*;

   localparam int STEP_W = $clog2(MAX_TAPS);
   localparam int CNT_W  = $clog2(MAX_TAPS + 1);
   localparam int CMP_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;

   typedef enum logic [1:0] {IDLE, RUN, DRAIN, DONE} state_type;

   state_type          state_ff;
   logic [STEP_W-1:0]  step_ff;
   logic [CFG_W-1:0]   tap_count_ff;
   sample_type         sample_ff;
   logic               last_ff;
   sample_type         carry_ff;
   logic               rsp_valid_ff;
   sample_type         rsp_filtered_ff;
   logic               rsp_block_end_ff;

   logic               req_accept;
   logic               out_free;
   logic               last_step;
   logic [CMP_W-1:0]   tap_wide;
   logic [CMP_W-1:0]   taps_eff;
   logic               in_taps;
   sample_type         head;
   sample_type         ring_hist_in;
   mac_ctrl_type       mac_ctrl;
   acc_type            acc;

   sample_type         hist_q  [MAX_TAPS];
   sample_type         coef_q  [MAX_TAPS];
   cell_ctrl_type      cell_ctrl [MAX_TAPS];

   assign req_stall  = (state_ff != IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign last_step  = (step_ff == STEP_W'(MAX_TAPS - 1));
   assign csr_ready  = 1'b1;

   // Clamp the tap count to the ring length
   always_comb begin
      tap_wide = CMP_W'(tap_count_ff);
      taps_eff = (tap_wide > CMP_W'(MAX_TAPS)) ? CMP_W'(MAX_TAPS) : tap_wide;
      in_taps  = (CMP_W'(step_ff) < taps_eff);
   end

   // Ring head: the new sample stands in for history entry zero
   assign head = (step_ff == '0) ? sample_ff : hist_q[0];

   // Refill the tail: zero first, then delayed entries inside the taps, else unchanged
   always_comb begin
      if (step_ff == '0) begin
         ring_hist_in = '0;
      end else if (in_taps) begin
         ring_hist_in = carry_ff;
      end else begin
         ring_hist_in = head;
      end
   end

   always_comb begin
      mac_ctrl.clear = req_accept && (req_opcode == OP_FILTER);
      mac_ctrl.issue = (state_ff == RUN) && in_taps;
   end

   // Row of cells, each rotating towards cell zero
   for (genvar j = 0; j < MAX_TAPS; j++) begin : g_cell
      always_comb begin
         cell_ctrl[j].shift   = (state_ff == RUN);
         cell_ctrl[j].coef_we = req_accept && (req_opcode == OP_COEF)
                                && (CMP_W'(req_coef_index) == CMP_W'(j));
      end

      if (j == MAX_TAPS - 1) begin : g_tail
         qfir_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (cell_ctrl[j]),
            .hist_in    (ring_hist_in),
            .coef_in    (coef_q[0]),
            .coef_wdata (req_coef_value),
            .hist_q     (hist_q[j]),
            .coef_q     (coef_q[j])
         );
      end else begin : g_body
         qfir_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (cell_ctrl[j]),
            .hist_in    (hist_q[j+1]),
            .coef_in    (coef_q[j+1]),
            .coef_wdata (req_coef_value),
            .hist_q     (hist_q[j]),
            .coef_q     (coef_q[j])
         );
      end
   end

   qfir_mac u_mac (
      .clock (clock),
      .reset (reset),
      .ctrl  (mac_ctrl),
      .hist  (head),
      .coef  (coef_q[0]),
      .acc   (acc)
   );

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         tap_count_ff <= CFG_W'(1);
      end else if (csr_valid && csr_ready) begin
         tap_count_ff <= csr_wdata;
      end
   end

   // Sequencer and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // drop the result once taken, unless the next one is loaded now
         if (rsp_valid_ff && !rsp_stall && (state_ff != DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            IDLE: begin
               if (req_accept && (req_opcode == OP_FILTER)) begin
                  sample_ff <= req_sample;
                  last_ff   <= req_last_sample;
                  step_ff   <= '0;
                  state_ff  <= RUN;
               end
            end
            RUN: begin
               carry_ff <= head;
               step_ff  <= step_ff + STEP_W'(1);
               if (last_step) begin
                  state_ff <= DRAIN;
               end
            end
            DRAIN: begin
               state_ff <= DONE;
            end
            DONE: begin
               if (out_free) begin
                  rsp_filtered_ff  <= acc[ACC_W-1:OUT_SHIFT];
                  rsp_block_end_ff <= last_ff;
                  rsp_valid_ff     <= 1'b1;
                  state_ff         <= IDLE;
               end
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_filtered  = rsp_filtered_ff;
   assign rsp_block_end = rsp_block_end_ff;

   // A result appears only when the sequencer leaves its final state
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == DONE))
      else $error("result raised outside DONE");

   // The ring turns exactly once per sample
   a_run_to_drain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == RUN && last_step) |=> (state_ff == DRAIN))
      else $error("ring turn did not end after MAX_TAPS steps");

   // No product is issued unless the ring is turning
   a_issue_in_run: assert property (@(posedge clock) disable iff (reset)
      mac_ctrl.issue |-> (state_ff == RUN))
      else $error("product issued while not running");

   // Coefficients are never loaded while the ring turns
   a_no_write_in_run: assert property (@(posedge clock) disable iff (reset)
      (state_ff == RUN) |-> !cell_ctrl[0].coef_we)
      else $error("coefficient load during rotation");

endmodule
